FILE: sv/rhc_pkg.sv
`default_nettype none
package rhc_pkg;

   // Quotient bits produced by the divider row, one per cell.
   localparam int unsigned Q_W   = 9;
   // Divisors are eight bits wide and start shifted up by Q_W - 1 places.
   localparam int unsigned D_W   = 8;
   localparam int unsigned DSH_W = D_W + Q_W - 1;
   localparam int unsigned NUM_W = DSH_W + 1;

   localparam int unsigned HUE_W = 9;
   localparam int unsigned PCT_W = 7;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [PCT_W-1:0] saturation;
      logic [PCT_W-1:0] brightness_value;
   } rsp_type;

   // Partial division state handed from one cell to the next.
   typedef struct packed {
      logic [NUM_W-1:0] hue_rem;
      logic [DSH_W-1:0] hue_dsh;
      logic [Q_W-1:0]   hue_q;
      logic [NUM_W-1:0] sat_rem;
      logic [DSH_W-1:0] sat_dsh;
      logic [Q_W-1:0]   sat_q;
      logic [PCT_W-1:0] val;
   } stage_type;

endpackage
`default_nettype wire

FILE: sv/rhc_front.sv
`default_nettype none
module rhc_front
   import rhc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire req_type   in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output stage_type      out_data
);

   logic      valid_ff, valid_in;
   stage_type data_ff, data_in;

   logic [7:0]  r, g, b, mx, mn, d;
   logic [10:0] d6, n;
   logic [NUM_W-1:0] hue_num;
   logic [14:0] mx100;
   logic [15:0] x1, vsum;

   assign r = in_data.red;
   assign g = in_data.green;
   assign b = in_data.blue;

   always_comb begin
      mx = (r > g) ? r : g;
      if (b > mx) begin
         mx = b;
      end
      mn = (r < g) ? r : g;
      if (b < mn) begin
         mn = b;
      end
      d  = mx - mn;
      d6 = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};

      // Ties for the maximum go to red, then green.
      priority if (mx == r) begin
         if (g < b) begin
            n = {3'b000, g} + d6 - {3'b000, b};
         end else begin
            n = {3'b000, g} - {3'b000, b};
         end
      end else if (mx == g) begin
         n = {3'b000, b} + {2'b00, d, 1'b0} - {3'b000, r};
      end else begin
         n = {3'b000, r} + {1'b0, d, 2'b00} - {3'b000, g};
      end

      // 60n as 64n - 4n.
      hue_num = {n, 6'b000000} - {4'b0000, n, 2'b00};

      // Value is mx*100/255; the divide by 255 uses (x+1 + (x+1)/256)/256.
      mx100 = {mx, 6'b000000} + {2'b00, mx, 5'b00000} + {5'b00000, mx, 2'b00};
      x1    = {1'b0, mx100} + 16'd1;
      vsum  = x1 + {8'h00, x1[15:8]};

      data_in.hue_rem = hue_num;
      data_in.hue_dsh = {d, {(Q_W-1){1'b0}}};
      data_in.hue_q   = '0;
      data_in.sat_rem = NUM_W'({d, 6'b000000} + {2'b00, d, 5'b00000} + {5'b00000, d, 2'b00});
      data_in.sat_dsh = {mx, {(Q_W-1){1'b0}}};
      data_in.sat_q   = '0;
      data_in.val     = vsum[8+PCT_W-1:8];
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

FILE: sv/rhc_div_cell.sv
`default_nettype none
module rhc_div_cell
   import rhc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire stage_type in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output stage_type      out_data
);

   logic      valid_ff, valid_in;
   stage_type data_ff, data_in;
   logic      hue_take, sat_take;

   // A zero divisor never subtracts, so grey and black pixels give zero quotients.
   always_comb begin
      hue_take = (in_data.hue_dsh != '0) && ({1'b0, in_data.hue_dsh} <= in_data.hue_rem);
      sat_take = (in_data.sat_dsh != '0) && ({1'b0, in_data.sat_dsh} <= in_data.sat_rem);

      data_in         = in_data;
      data_in.hue_rem = hue_take ? in_data.hue_rem - {1'b0, in_data.hue_dsh} : in_data.hue_rem;
      data_in.hue_dsh = in_data.hue_dsh >> 1;
      data_in.hue_q   = {in_data.hue_q[Q_W-2:0], hue_take};
      data_in.sat_rem = sat_take ? in_data.sat_rem - {1'b0, in_data.sat_dsh} : in_data.sat_rem;
      data_in.sat_dsh = in_data.sat_dsh >> 1;
      data_in.sat_q   = {in_data.sat_q[Q_W-2:0], sat_take};
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

FILE: sv/rgb_to_hsv_converter.sv
// Pipeline: an accepted request passes one front stage and then a row of
// nine divider cells that each resolve one quotient bit, all registered.
// Throughput: one request per cycle when not stalled; every stage holds its
// own valid bit, so a stalled result only holds back full stages behind it.
// Reset: synchronous, active high, clears the valid bits of all stages.
`default_nettype none
module rgb_to_hsv_converter
   import rhc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic      front_valid, front_ready;
   stage_type front_data;

   logic      cell_valid [Q_W+1];
   logic      cell_ready [Q_W+1];
   stage_type cell_data  [Q_W+1];

   rhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_ready (cell_ready[0]),
      .out_data  (front_data)
   );

   assign req_stall     = !front_ready;
   assign cell_valid[0] = front_valid;
   assign cell_data[0]  = front_data;

   for (genvar k = 0; k < Q_W; k++) begin : g_cell
      rhc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[k]),
         .in_ready  (cell_ready[k]),
         .in_data   (cell_data[k]),
         .out_valid (cell_valid[k+1]),
         .out_ready (cell_ready[k+1]),
         .out_data  (cell_data[k+1])
      );
   end

   assign cell_ready[Q_W] = !rsp_stall;

   assign rsp_valid                 = cell_valid[Q_W];
   assign rsp_data.hue              = cell_data[Q_W].hue_q[HUE_W-1:0];
   assign rsp_data.saturation       = cell_data[Q_W].sat_q[PCT_W-1:0];
   assign rsp_data.brightness_value = cell_data[Q_W].val;

`ifndef SYNTH
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hue < 9'd360) && (rsp_data.saturation <= 7'd100)
                    && (rsp_data.brightness_value <= 7'd100))
      else $error("result field out of range");

   a_accept_fills_front: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> front_valid)
      else $error("accepted request lost at front stage");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> front_valid)
      else $error("request stalled with an empty front stage");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rhc_pkg::*;

   localparam int unsigned RANDOM_PIXELS = 2000;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned DRAIN_CYCLES  = 24;
   localparam int unsigned IDLE_PERCENT  = 6;

   typedef struct {
      req_type pix;
      bit      pinned;
      rsp_type want;
   } probe_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   // While set, neither side inserts idle cycles.
   bit          steady = 1'b0;
   rsp_type     hsv_pending[$];
   probe_type   probes[$];
   int unsigned mismatches = 0;
   int unsigned cycles = 0;

   rgb_to_hsv_converter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic rsp_type hsv_of(req_type p);
      int unsigned r, g, b, hi, lo, span, n;
      rsp_type     o;
      r    = p.red;
      g    = p.green;
      b    = p.blue;
      hi   = (r > g) ? r : g;
      hi   = (hi > b) ? hi : b;
      lo   = (r < g) ? r : g;
      lo   = (lo < b) ? lo : b;
      span = hi - lo;
      o.brightness_value = PCT_W'((hi * 100) / 255);
      o.saturation       = (hi == 0) ? '0 : PCT_W'((span * 100) / hi);
      o.hue              = '0;
      if (span != 0) begin
         // Ties on the maximum go to red first, then green.
         if (hi == r) begin
            n = (g < b) ? g + 6 * span - b : g - b;
         end else if (hi == g) begin
            n = b + 2 * span - r;
         end else begin
            n = r + 4 * span - g;
         end
         o.hue = HUE_W'((60 * n) / span);
      end
      return o;
   endfunction

   task automatic row(input int r, input int g, input int b, input bit pinned,
                      input int h, input int s, input int v);
      probe_type p;
      p.pix    = '{red: 8'(r), green: 8'(g), blue: 8'(b)};
      p.pinned = pinned;
      p.want   = '{hue: HUE_W'(h), saturation: PCT_W'(s), brightness_value: PCT_W'(v)};
      probes.push_back(p);
   endtask

   // Presents one request and returns at the edge that accepts it.
   task automatic send_pixel(input req_type pix, input bit pinned, input rsp_type want);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      hsv_pending.push_back(pinned ? want : hsv_of(pix));
   endtask

   function automatic req_type random_pixel();
      req_type p;
      p = 24'($urandom);
      case ($urandom_range(0, 7))
         0: begin
            p.green = p.red;
            p.blue  = p.red;
         end
         1: begin
            case ($urandom_range(0, 2))
               0: p.green = p.red;
               1: p.blue  = p.green;
               default: p.red = p.blue;
            endcase
         end
         2: begin
            if ($urandom_range(0, 1)) p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            if ($urandom_range(0, 1)) p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            if ($urandom_range(0, 1)) p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         default: ;
      endcase
      return p;
   endfunction

   initial begin
      //   red  green blue  pinned hue  sat  val
      row(   0,    0,    0, 1,       0,   0,   0);
      row( 255,  255,  255, 1,       0,   0, 100);
      row( 255,    0,    0, 1,       0, 100, 100);
      row(   0,  255,    0, 1,     120, 100, 100);
      row(   0,    0,  255, 1,     240, 100, 100);
      row( 255,  255,    0, 1,      60, 100, 100);
      row(   0,  255,  255, 1,     180, 100, 100);
      row( 255,    0,  255, 1,     300, 100, 100);
      row( 255,    0,    1, 1,     359, 100, 100);
      row( 128,  128,  128, 1,       0,   0,  50);
      row(   1,    1,    1, 1,       0,   0,   0);
      row(   1,    0,    0, 1,       0, 100,   0);
      row( 254,    1,    0, 0,       0,   0,   0);
      row(   0,    1,  255, 0,       0,   0,   0);
      row( 170,   85,  255, 0,       0,   0,   0);
      row(  85,  170,    0, 0,       0,   0,   0);
      row( 255,  254,  254, 0,       0,   0,   0);
      row( 254,  255,  255, 0,       0,   0,   0);
      row(   1,    2,    3, 0,       0,   0,   0);
      row( 200,  100,  100, 0,       0,   0,   0);
      row(  37,  201,  144, 0,       0,   0,   0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (probes[i]) send_pixel(probes[i].pix, probes[i].pinned, probes[i].want);

      // Hold off the sender until the pipeline has drained completely.
      req_valid <= 1'b0;
      @(posedge clock);
      while (hsv_pending.size() != 0) @(posedge clock);

      for (int unsigned i = 0; i < RANDOM_PIXELS; i++) begin
         if (i == 700) steady <= 1'b1;
         if (i == 1200) steady <= 1'b0;
         send_pixel(random_pixel(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (hsv_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
         if (rsp_valid && !rsp_stall) begin
            if (hsv_pending.size() == 0) begin
               $display("%0t: result with no request outstanding, actual %p", $time, rsp_data);
               mismatches++;
            end else begin
               want = hsv_pending.pop_front();
               if (rsp_data.hue !== want.hue) begin
                  $display("%0t: hue expected %0d actual %0d", $time, want.hue, rsp_data.hue);
                  mismatches++;
               end
               if (rsp_data.saturation !== want.saturation) begin
                  $display("%0t: saturation expected %0d actual %0d",
                           $time, want.saturation, rsp_data.saturation);
                  mismatches++;
               end
               if (rsp_data.brightness_value !== want.brightness_value) begin
                  $display("%0t: value expected %0d actual %0d",
                           $time, want.brightness_value, rsp_data.brightness_value);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule
